// ===== hw/rtl/nnu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the nearest-neighbor upscaler.
package nnu_pkg;

    // Geometry limits
    localparam int MAX_DIM    = 4096;
    localparam int MAX_REPEAT = 8;

    // Field widths fixed by the interface
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PIXEL_W   = 32;
    localparam int COORD_W   = 12;
    localparam int INDEX_W   = 24;

    // Derived widths
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int SUM_W      = DIM_W + 1;
    localparam int REP_W      = $clog2(MAX_REPEAT + 1);
    localparam int RIDX_W     = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
    localparam int DIV_CNT_W  = $clog2(DIM_W + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_cfg_reg;

    // Controller states
    typedef enum logic [2:0] {
        ST_DIVX_GO,
        ST_DIVX_RUN,
        ST_DIVY_GO,
        ST_DIVY_RUN,
        ST_IDLE,
        ST_PREP,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic div_go;
        logic div_sel_y;
        logic store_x;
        logic store_y;
        logic in_ready;
        logic prep;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last_write;
    } t_sts;

    // Effective dimension: zero acts as one, oversize clamps to the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Repeat count ceil(d/s) from quotient and remainder, capped
    function automatic logic [REP_W-1:0] repeat_count(input logic [DIM_W-1:0] q,
                                                      input logic [CNT_W-1:0] r);
        logic [SUM_W-1:0] c;
        logic [REP_W-1:0] res;
        c = SUM_W'(q) + SUM_W'(r != '0);
        if (int'(c) > MAX_REPEAT) begin
            res = REP_W'(MAX_REPEAT);
        end else begin
            res = REP_W'(c);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/nnu_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the scale step quotients.
module nnu_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [nnu_pkg::DIM_W-1:0] i_dividend,
    input  logic [nnu_pkg::DIM_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [nnu_pkg::DIM_W-1:0] o_quotient,
    output logic [nnu_pkg::CNT_W-1:0] o_remainder
);

    logic [nnu_pkg::DIM_W-1:0]     r_rem;
    logic [nnu_pkg::DIM_W-1:0]     r_quo;
    logic [nnu_pkg::DIM_W-1:0]     r_div;
    logic [nnu_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [nnu_pkg::DIM_W:0]   w_trial;
    logic [nnu_pkg::DIM_W:0]   w_diff;
    logic                      w_ge;
    logic [nnu_pkg::DIM_W-1:0] n_rem;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_quo[nnu_pkg::DIM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[nnu_pkg::DIM_W-1:0] : w_trial[nnu_pkg::DIM_W-1:0];
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= nnu_pkg::DIV_CNT_W'(nnu_pkg::DIM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - nnu_pkg::DIV_CNT_W'(1);
                if (r_cnt == nnu_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[nnu_pkg::DIM_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = nnu_pkg::CNT_W'(r_rem);

endmodule

// ===== hw/rtl/nnu_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: divider setup, pixel acceptance and write sequencing.
module nnu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  nnu_pkg::t_sts i_sts,
    output nnu_pkg::t_cmd o_cmd
);

    nnu_pkg::t_state r_state;
    nnu_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnu_pkg::ST_DIVX_GO;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            nnu_pkg::ST_DIVX_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = nnu_pkg::ST_DIVX_RUN;
            end
            nnu_pkg::ST_DIVX_RUN: begin
                if (i_sts.div_done) begin
                    o_cmd.store_x = 1'b1;
                    n_state       = nnu_pkg::ST_DIVY_GO;
                end
            end
            nnu_pkg::ST_DIVY_GO: begin
                o_cmd.div_go    = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = nnu_pkg::ST_DIVY_RUN;
            end
            nnu_pkg::ST_DIVY_RUN: begin
                o_cmd.div_sel_y = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.store_y = 1'b1;
                    n_state       = nnu_pkg::ST_IDLE;
                end
            end
            nnu_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = nnu_pkg::ST_PREP;
                end
            end
            nnu_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = nnu_pkg::ST_EMIT;
            end
            nnu_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_write) begin
                        n_state = nnu_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = nnu_pkg::ST_DIVX_GO;
            end
        endcase
        // A register write invalidates the step quotients: redo them
        if (i_cfg_valid) begin
            n_state = nnu_pkg::ST_DIVX_GO;
        end
    end

    // An accepted pixel moves on to index preparation unless a register write comes in the same cycle
    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_cmd.in_ready && !i_cfg_valid) |=> (r_state == nnu_pkg::ST_PREP))
        else $error("accepted pixel did not enter preparation");

    // Writes leave only while a pixel is in progress
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> $past(r_state == nnu_pkg::ST_PREP || r_state == nnu_pkg::ST_EMIT))
        else $error("write issued without a pixel in progress");

endmodule

// ===== hw/rtl/nnu_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, position tracking, write generation and output register.
module nnu_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [nnu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnu_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [nnu_pkg::PIXEL_W-1:0]   i_src_pixel,
    input  logic                          i_out_stall,
    input  nnu_pkg::t_cmd                 i_cmd,
    output nnu_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    output logic [nnu_pkg::COORD_W-1:0]   o_out_x,
    output logic [nnu_pkg::COORD_W-1:0]   o_out_y,
    output logic [nnu_pkg::INDEX_W-1:0]   o_out_index,
    output logic [nnu_pkg::PIXEL_W-1:0]   o_out_pixel,
    output logic                          o_last_copy,
    output logic                          o_frame_end
);

    // Configuration registers
    logic [nnu_pkg::CFG_W-1:0] r_src_width;
    logic [nnu_pkg::CFG_W-1:0] r_src_height;
    logic [nnu_pkg::CFG_W-1:0] r_dst_width;
    logic [nnu_pkg::CFG_W-1:0] r_dst_height;

    logic [nnu_pkg::DIM_W-1:0] w_sw;
    logic [nnu_pkg::DIM_W-1:0] w_sh;
    logic [nnu_pkg::DIM_W-1:0] w_dw;
    logic [nnu_pkg::DIM_W-1:0] w_dh;

    // Step quotients and repeat counts
    logic [nnu_pkg::DIM_W-1:0] r_qx;
    logic [nnu_pkg::CNT_W-1:0] r_rx;
    logic [nnu_pkg::DIM_W-1:0] r_qy;
    logic [nnu_pkg::CNT_W-1:0] r_ry;
    logic [nnu_pkg::REP_W-1:0] r_rep_x;
    logic [nnu_pkg::REP_W-1:0] r_rep_y;

    logic                      w_div_done;
    logic [nnu_pkg::DIM_W-1:0] w_div_q;
    logic [nnu_pkg::CNT_W-1:0] w_div_r;

    // Source position
    logic [nnu_pkg::CNT_W-1:0] r_col_count;
    logic [nnu_pkg::CNT_W-1:0] r_row_count;
    logic [nnu_pkg::CNT_W-1:0] r_col_base;
    logic [nnu_pkg::CNT_W-1:0] r_col_res;
    logic [nnu_pkg::CNT_W-1:0] r_row_base;
    logic [nnu_pkg::CNT_W-1:0] r_row_res;

    logic                      w_col_last;
    logic                      w_row_last;
    logic [nnu_pkg::SUM_W-1:0] w_col_sum;
    logic [nnu_pkg::SUM_W-1:0] w_row_sum;
    logic                      w_col_carry;
    logic                      w_row_carry;
    logic [nnu_pkg::CNT_W-1:0] n_col_res;
    logic [nnu_pkg::CNT_W-1:0] n_row_res;
    logic [nnu_pkg::CNT_W-1:0] n_col_base;
    logic [nnu_pkg::CNT_W-1:0] n_row_base;

    // Current pixel
    logic [nnu_pkg::PIXEL_W-1:0] r_pixel;
    logic [nnu_pkg::INDEX_W-1:0] r_prod;
    logic [nnu_pkg::CNT_W-1:0]   r_x0;
    logic [nnu_pkg::DIM_W-1:0]   r_x;
    logic [nnu_pkg::DIM_W-1:0]   r_y;
    logic [nnu_pkg::INDEX_W-1:0] r_idx;
    logic [nnu_pkg::INDEX_W-1:0] r_row_idx;
    logic [nnu_pkg::RIDX_W-1:0]  r_i;
    logic [nnu_pkg::RIDX_W-1:0]  r_j;
    logic                        r_last_pixel;

    logic w_accept;
    logic w_i_last;
    logic w_j_last;
    logic w_last;

    // Output register
    logic                        r_out_valid;
    logic [nnu_pkg::COORD_W-1:0] r_out_x;
    logic [nnu_pkg::COORD_W-1:0] r_out_y;
    logic [nnu_pkg::INDEX_W-1:0] r_out_index;
    logic [nnu_pkg::PIXEL_W-1:0] r_out_pixel;
    logic                        r_last_copy;
    logic                        r_frame_end;
    logic                        w_out_free;

    assign w_accept = i_in_valid && i_cmd.in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= nnu_pkg::CFG_W'(640);
            r_src_height <= nnu_pkg::CFG_W'(480);
            r_dst_width  <= nnu_pkg::CFG_W'(640);
            r_dst_height <= nnu_pkg::CFG_W'(480);
        end else if (i_cfg_valid) begin
            unique case (nnu_pkg::t_cfg_reg'(i_cfg_index))
                nnu_pkg::REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                nnu_pkg::REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                nnu_pkg::REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                nnu_pkg::REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sw = nnu_pkg::eff_dim(r_src_width);
    assign w_sh = nnu_pkg::eff_dim(r_src_height);
    assign w_dw = nnu_pkg::eff_dim(r_dst_width);
    assign w_dh = nnu_pkg::eff_dim(r_dst_height);

    // Divide destination by source size for each axis
    nnu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_go),
        .i_dividend  (i_cmd.div_sel_y ? w_dh : w_dw),
        .i_divisor   (i_cmd.div_sel_y ? w_sh : w_sw),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    // Capture step quotients and repeat counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_x) begin
            r_qx    <= w_div_q;
            r_rx    <= w_div_r;
            r_rep_x <= nnu_pkg::repeat_count(w_div_q, w_div_r);
        end
        if (i_cmd.store_y) begin
            r_qy    <= w_div_q;
            r_ry    <= w_div_r;
            r_rep_y <= nnu_pkg::repeat_count(w_div_q, w_div_r);
        end
    end

    // Next block corner: add the step quotient, carry the remainder
    always_comb begin
        w_col_last  = (nnu_pkg::DIM_W'(r_col_count) == w_sw - nnu_pkg::DIM_W'(1));
        w_row_last  = (nnu_pkg::DIM_W'(r_row_count) == w_sh - nnu_pkg::DIM_W'(1));
        w_col_sum   = nnu_pkg::SUM_W'(r_col_res) + nnu_pkg::SUM_W'(r_rx);
        w_row_sum   = nnu_pkg::SUM_W'(r_row_res) + nnu_pkg::SUM_W'(r_ry);
        w_col_carry = (w_col_sum >= nnu_pkg::SUM_W'(w_sw));
        w_row_carry = (w_row_sum >= nnu_pkg::SUM_W'(w_sh));
        n_col_res   = w_col_carry ? nnu_pkg::CNT_W'(w_col_sum - nnu_pkg::SUM_W'(w_sw))
                                  : nnu_pkg::CNT_W'(w_col_sum);
        n_row_res   = w_row_carry ? nnu_pkg::CNT_W'(w_row_sum - nnu_pkg::SUM_W'(w_sh))
                                  : nnu_pkg::CNT_W'(w_row_sum);
        n_col_base  = nnu_pkg::CNT_W'(nnu_pkg::SUM_W'(r_col_base) + nnu_pkg::SUM_W'(r_qx)
                                      + nnu_pkg::SUM_W'(w_col_carry));
        n_row_base  = nnu_pkg::CNT_W'(nnu_pkg::SUM_W'(r_row_base) + nnu_pkg::SUM_W'(r_qy)
                                      + nnu_pkg::SUM_W'(w_row_carry));
    end

    // Advance the source position on each accepted pixel; restart on register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_base  <= '0;
            r_col_res   <= '0;
            r_row_base  <= '0;
            r_row_res   <= '0;
        end else if (w_accept) begin
            if (w_col_last) begin
                r_col_count <= '0;
                r_col_base  <= '0;
                r_col_res   <= '0;
                if (w_row_last) begin
                    r_row_count <= '0;
                    r_row_base  <= '0;
                    r_row_res   <= '0;
                end else begin
                    r_row_count <= r_row_count + nnu_pkg::CNT_W'(1);
                    r_row_base  <= n_row_base;
                    r_row_res   <= n_row_res;
                end
            end else begin
                r_col_count <= r_col_count + nnu_pkg::CNT_W'(1);
                r_col_base  <= n_col_base;
                r_col_res   <= n_col_res;
            end
        end
    end

    // Write position within the block
    always_comb begin
        w_i_last = (nnu_pkg::REP_W'(r_i) == r_rep_x - nnu_pkg::REP_W'(1));
        w_j_last = (nnu_pkg::REP_W'(r_j) == r_rep_y - nnu_pkg::REP_W'(1));
        w_last   = w_i_last && w_j_last;
    end

    // Load the pixel, form the row offset, then step through the block
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel      <= i_src_pixel;
            r_prod       <= nnu_pkg::INDEX_W'(r_row_base * w_dw);
            r_x0         <= r_col_base;
            r_x          <= nnu_pkg::DIM_W'(r_col_base);
            r_y          <= nnu_pkg::DIM_W'(r_row_base);
            r_i          <= '0;
            r_j          <= '0;
            r_last_pixel <= w_col_last && w_row_last;
        end else if (i_cmd.prep) begin
            r_idx     <= r_prod + nnu_pkg::INDEX_W'(r_x0);
            r_row_idx <= r_prod + nnu_pkg::INDEX_W'(r_x0);
        end else if (i_cmd.emit) begin
            if (w_i_last) begin
                r_i       <= '0;
                r_j       <= r_j + nnu_pkg::RIDX_W'(1);
                r_x       <= nnu_pkg::DIM_W'(r_x0);
                r_y       <= r_y + nnu_pkg::DIM_W'(1);
                r_row_idx <= r_row_idx + nnu_pkg::INDEX_W'(w_dw);
                r_idx     <= r_row_idx + nnu_pkg::INDEX_W'(w_dw);
            end else begin
                r_i   <= r_i + nnu_pkg::RIDX_W'(1);
                r_x   <= r_x + nnu_pkg::DIM_W'(1);
                r_idx <= r_idx + nnu_pkg::INDEX_W'(1);
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Output register: fill on a write, drop when the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x     <= nnu_pkg::COORD_W'(r_x);
            r_out_y     <= nnu_pkg::COORD_W'(r_y);
            r_out_index <= r_idx;
            r_out_pixel <= r_pixel;
            r_last_copy <= w_last;
            r_frame_end <= w_last && r_last_pixel;
        end
    end

    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.last_write = w_last;

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_index = r_out_index;
    assign o_out_pixel = r_out_pixel;
    assign o_last_copy = r_last_copy;
    assign o_frame_end = r_frame_end;

    // Frame end only marks the final write of a pixel
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_end) |-> r_last_copy)
        else $error("frame end flagged on a write that is not the last copy");

    // Source position stays inside the effective source image
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (nnu_pkg::DIM_W'(r_col_count) < w_sw) && (nnu_pkg::DIM_W'(r_row_count) < w_sh))
        else $error("source position outside the source image");

    // Block counters stay within the repeat counts while writing
    a_block_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (nnu_pkg::REP_W'(r_i) < r_rep_x) && (nnu_pkg::REP_W'(r_j) < r_rep_y))
        else $error("block counter beyond repeat count");

endmodule

// ===== hw/rtl/nearest_neighbor_upscaler.sv =====
`timescale 1ns / 1ps
// Top level of the nearest-neighbor upscaler: controller plus datapath.
//
// Takes source pixels in raster order and issues destination writes for a
// nearest-neighbor scaled copy: each pixel fills a block of up to 8 x 8 writes
// starting at (floor(x*dst_w/src_w), floor(y*dst_h/src_h)), one write per clock
// while the output is not stalled. One pixel is processed at a time: it is
// accepted, its start index is formed, then its rx*ry writes are issued, where
// rx = min(ceil(dst_w/src_w), 8) and ry likewise, by the single write sequencer
// and its output register. The next pixel is accepted while the last write of the
// previous one still waits in the output register. Block corners advance by
// add-and-compare steps using per-axis step quotients from a shared bit-serial
// divider; after reset and after every register write the divider runs twice
// with the input stalled. Any register write restarts the frame at source pixel
// (0,0); zero sizes act as 1, sizes above 4096 as 4096.
module nearest_neighbor_upscaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nnu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nnu_pkg::CFG_W-1:0]           i_cfg_data,
    // Source pixel channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [nnu_pkg::PIXEL_W-1:0]         i_src_pixel,
    // Destination write channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [nnu_pkg::COORD_W-1:0]         o_out_x,
    output logic [nnu_pkg::COORD_W-1:0]         o_out_y,
    output logic [nnu_pkg::INDEX_W-1:0]         o_out_index,
    output logic [nnu_pkg::PIXEL_W-1:0]         o_out_pixel,
    output logic                                o_last_copy,
    output logic                                o_frame_end
);

    nnu_pkg::t_cmd w_cmd;
    nnu_pkg::t_sts w_sts;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_cmd.in_ready;

    nnu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nnu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_src_pixel (i_src_pixel),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_index (o_out_index),
        .o_out_pixel (o_out_pixel),
        .o_last_copy (o_last_copy),
        .o_frame_end (o_frame_end)
    );

endmodule
